/* hdl/genotype_recode_engine_macros.svh */
// Assertion macros shared by the checker of genotype_recode_engine.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef GENOTYPE_RECODE_ENGINE_MACROS_SVH
`define GENOTYPE_RECODE_ENGINE_MACROS_SVH

// checked only out of reset
`define GRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/grec_pkg.sv */
// Shared types, codes and constants of the genotype recode engine.
// No dependencies.
package grec_pkg;

  localparam int ROW_SAMPLES_MAX_DEF = 4096;

  localparam int IDX_W  = 12;
  localparam int VAL_W  = 16;
  localparam int LET_W  = 8;
  localparam int MODE_W = 3;
  localparam int SUM_W  = 29;
  localparam int CNT_W  = 13;
  localparam int FRAC_W = 14;
  localparam int CFG_ADDR_W = 1;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_END  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DOM  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HET  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLIP = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MISS = 3'd6;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MISS = 1'b1;

  localparam logic [VAL_W-1:0] Q_ONE    = 16'd16384;
  localparam logic [VAL_W-1:0] Q_TWO    = 16'd32768;
  localparam logic [VAL_W-1:0] MISS_RST = 16'hFFFF;

  localparam logic [LET_W-1:0] LET_T = 8'h54;
  localparam logic [LET_W-1:0] LET_M = 8'h4D;
  localparam logic [LET_W-1:0] LET_Y = 8'h59;
  localparam logic [LET_W-1:0] LET_N = 8'h4E;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] sample_index;
    logic [VAL_W-1:0] sample_value;
    logic [LET_W-1:0] allele_first;
    logic [LET_W-1:0] allele_second;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] recoded_value;
    logic [LET_W-1:0] allele_first_out;
    logic [LET_W-1:0] allele_second_out;
    logic             row_flipped;
    logic             result_kind;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic row_end;
    logic read;
    logic read_done;
  } grec_cmd_t;

  typedef struct packed {
    logic out_free;
  } grec_status_t;

endpackage

/* hdl/grec_ctrl.sv */
// Controller of the genotype recode engine: handshake and read sequencing.
// Depends on grec_pkg.
module grec_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           req_type,
  output logic                 in_ready,
  input  grec_pkg::grec_status_t status,
  output grec_pkg::grec_cmd_t  cmd
);
  import grec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   needs_out;
  logic   acc;

  assign needs_out = (req_type == REQ_END) || (req_type == REQ_READ);
  assign in_ready  = (state_r == ST_IDLE) && (status.out_free || !needs_out);
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd.load      = acc && (req_type == REQ_LOAD);
    cmd.row_end   = acc && (req_type == REQ_END);
    cmd.read      = acc && (req_type == REQ_READ);
    cmd.read_done = (state_r == ST_READ);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (req_type == REQ_READ)) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/grec_datapath.sv */
// Datapath of the genotype recode engine: sample store, row sum and count,
// flip decision, recoding and the output register. Depends on grec_pkg.
module grec_datapath #(
  parameter int ROW_SAMPLES_MAX = grec_pkg::ROW_SAMPLES_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [grec_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [grec_pkg::VAL_W-1:0]          cfg_wdata,
  input  grec_pkg::in_word_t                  in_data,
  input  grec_pkg::grec_cmd_t                 cmd,
  output grec_pkg::grec_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output grec_pkg::out_word_t                 out_data
);
  import grec_pkg::*;

  localparam int AW = (ROW_SAMPLES_MAX > 1) ? $clog2(ROW_SAMPLES_MAX) : 1;
  localparam logic [16:0] DEPTH = 17'(ROW_SAMPLES_MAX);

  logic [VAL_W-1:0] mem [0:ROW_SAMPLES_MAX-1];

  logic [MODE_W-1:0] mode_r;
  logic [VAL_W-1:0]  miss_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              flip_r, flip_nxt;
  logic [VAL_W-1:0]  rd_data_r;
  logic              rd_oob_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       addr;
  logic                in_range;
  logic                val_present;
  logic [SUM_W-1:0]    limit;
  logic                flip_now;
  logic [VAL_W-1:0]    rd_val;

  function automatic logic [VAL_W-1:0] recode(
    input logic [VAL_W-1:0]  v,
    input logic [MODE_W-1:0] mode,
    input logic [VAL_W-1:0]  miss_code,
    input logic              flip
  );
    logic             miss;
    logic [VAL_W-1:0] r;
    miss = (v == miss_code);
    r    = v;
    case (mode)
      MODE_DOM: if (v == Q_ONE) r = Q_TWO;
      MODE_REC: if (v == Q_ONE) r = '0;
      MODE_HET: if (!miss) r = (v == Q_ONE) ? Q_TWO : '0;
      MODE_FLIP: begin
        if (flip && !miss) r = (v > Q_TWO) ? '0 : (Q_TWO - v);
      end
      MODE_MISS: r = miss ? Q_ONE : '0;
      default: r = v;
    endcase
    return r;
  endfunction

  assign idx_ext     = (AW+IDX_W)'(in_data.sample_index);
  assign addr        = idx_ext[AW-1:0];
  assign in_range    = 17'(in_data.sample_index) < DEPTH;
  assign val_present = (in_data.sample_value != miss_r);
  assign limit       = {2'b00, cnt_r, {FRAC_W{1'b0}}};
  assign flip_now    = (mode_r == MODE_FLIP) && (sum_r > limit);
  assign rd_val      = rd_oob_r ? '0 : rd_data_r;

  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    flip_nxt      = flip_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load && in_range && val_present) begin
      sum_nxt = sum_r + SUM_W'(in_data.sample_value);
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.row_end) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      if (mode_r == MODE_FLIP) flip_nxt = flip_now;
      out_nxt.recoded_value     = '0;
      out_nxt.allele_first_out  = in_data.allele_first;
      out_nxt.allele_second_out = in_data.allele_second;
      if (mode_r == MODE_HET) begin
        out_nxt.allele_first_out  = LET_T;
        out_nxt.allele_second_out = LET_M;
      end else if (mode_r == MODE_MISS) begin
        out_nxt.allele_first_out  = LET_Y;
        out_nxt.allele_second_out = LET_N;
      end else if (flip_now) begin
        out_nxt.allele_first_out  = in_data.allele_second;
        out_nxt.allele_second_out = in_data.allele_first;
      end
      out_nxt.row_flipped = flip_now;
      out_nxt.result_kind = 1'b1;
      out_valid_nxt       = 1'b1;
    end
    if (cmd.read_done) begin
      out_nxt.recoded_value     = recode(rd_val, mode_r, miss_r, flip_r);
      out_nxt.allele_first_out  = '0;
      out_nxt.allele_second_out = '0;
      out_nxt.row_flipped       = 1'b0;
      out_nxt.result_kind       = 1'b0;
      out_valid_nxt             = 1'b1;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.load && in_range) mem[addr] <= in_data.sample_value;
    if (cmd.read) rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.read) rd_oob_r <= !in_range;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      miss_r      <= MISS_RST;
      sum_r       <= '0;
      cnt_r       <= '0;
      flip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      flip_r      <= flip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
          CFG_MISS: miss_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

/* hdl/genotype_recode_engine.sv */
// genotype_recode_engine: top level, controller plus datapath. Uses grec_pkg.
// An end-of-row result is valid the cycle after acceptance. A read goes
// through the registered store read and the read state before its result
// is registered into the output. Synchronous active-low reset clears sum,
// count, flip, mode and out_valid, and sets the missing code to all ones.
module genotype_recode_engine #(
  parameter int ROW_SAMPLES_MAX = grec_pkg::ROW_SAMPLES_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [grec_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [grec_pkg::VAL_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  grec_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output grec_pkg::out_word_t             out_data
);
  import grec_pkg::*;

  grec_cmd_t    cmd;
  grec_status_t status;

  grec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  grec_datapath #(
    .ROW_SAMPLES_MAX (ROW_SAMPLES_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/grec_checker.sv */
// Port-level checker for genotype_recode_engine and its bind.
// Depends on grec_pkg and genotype_recode_engine_macros.svh.
`include "genotype_recode_engine_macros.svh"

module grec_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input grec_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input grec_pkg::out_word_t out_data
);
  import grec_pkg::*;

  `GRE_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `GRE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
  `GRE_ASSERT(a_end_result, in_valid && in_ready && in_data.req_type == REQ_END |=> out_valid && out_data.result_kind, "no end-of-row word")
  `GRE_ASSERT(a_read_result, in_valid && in_ready && in_data.req_type == REQ_READ |-> ##2 (out_valid && !out_data.result_kind), "no sample word")
  `GRE_ASSERT(a_sample_clean, out_valid && !out_data.result_kind |-> out_data.allele_first_out == 0 && out_data.allele_second_out == 0 && !out_data.row_flipped, "sample word carries row fields")

endmodule

bind genotype_recode_engine grec_port_checker u_grec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
